FILE: hdl/frdf_pkg.sv
// ----------------------------------------------------------------------------
// frdf_pkg
// Types and constants shared by the flood relay duplicate filter modules.
// ----------------------------------------------------------------------------
package frdf_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_OWN_ID         = 2'd0;
    localparam logic [1:0] CFG_SWEEP_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_STALE_AGE      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [47:0] OWN_ID_RST         = 48'd0;
    localparam logic [31:0] SWEEP_INTERVAL_RST = 32'd5000;
    localparam logic [31:0] STALE_AGE_RST      = 32'd10;

    // Verdict codes
    localparam logic [2:0] VERDICT_FWD       = 3'd0;
    localparam logic [2:0] VERDICT_DROP_SELF = 3'd1;
    localparam logic [2:0] VERDICT_DROP_OLD  = 3'd2;
    localparam logic [2:0] VERDICT_DROP_TTL  = 3'd3;
    localparam logic [2:0] VERDICT_TIME      = 3'd4;

    // Action codes
    localparam logic ACTION_PACKET = 1'b0;
    localparam logic ACTION_TIME   = 1'b1;

    localparam int unsigned CNT_W = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic               action;
        logic        [47:0] sender_id;
        logic        [31:0] lat_bits;
        logic        [31:0] lon_bits;
        logic        [31:0] stamp;
        logic signed [7:0]  hops_left;
        logic        [31:0] seq_in;
    } in_t;

    typedef struct packed {
        logic [2:0]       verdict;
        logic             not_recorded;
        logic [47:0]      fwd_id;
        logic [31:0]      fwd_lat;
        logic [31:0]      fwd_lon;
        logic [31:0]      fwd_stamp;
        logic [6:0]       fwd_hops;
        logic [31:0]      fwd_seq;
        logic             swept;
        logic [CNT_W-1:0] removed_count;
    } out_t;

    // Classified item passed from the front to the back
    typedef struct packed {
        in_t  pkt;
        logic self_drop;
        logic ttl_drop;
    } job_t;

    // One sender table entry
    typedef struct packed {
        logic [47:0] id;
        logic [31:0] seq;
        logic [31:0] stamp;
    } entry_t;

endpackage

FILE: hdl/flood_relay_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter_top
// Relay filter for a flooding mesh: drops own, stale-sequence and expired
// packets, records senders in a small table and ages the table out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid / in_stall / in_data) carry either a received packet
//   or a local time update. Every input beat yields exactly one result beat on
//   out_valid / out_stall / out_data, in order.
//   Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) set
//   own_id, sweep_interval and stale_age; cfg_ready is always high. Write them
//   only while no item is in flight.
//   Flow: the table walk reads one entry a cycle from the table memory. A packet
//   goes from the queue through the walk and the decide step to the output
//   register; a packet from this node skips the walk; a time update goes
//   through the sweep check, and through a stale sweep walk when one is due.
//   A two-beat queue sits at the input, so new beats are taken while the back
//   end is busy; in_stall rises only when that queue is full.
//   When the receiver stalls, the result beat is held unchanged in the output
//   register and the back end waits with its next result.
//   Reset empties the table and queue, clears local time and last sweep time,
//   and restores own_id 0, sweep_interval 5000 and stale_age 10.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter_top
    import frdf_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [47:0] own_id_reg;
    logic [31:0] sweep_interval_reg;
    logic [31:0] stale_age_reg;
    logic        job_valid;
    logic        job_pop;
    job_t        job_data;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg         <= OWN_ID_RST;
            sweep_interval_reg <= SWEEP_INTERVAL_RST;
            stale_age_reg      <= STALE_AGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OWN_ID:         own_id_reg         <= cfg_data;
                CFG_SWEEP_INTERVAL: sweep_interval_reg <= cfg_data[31:0];
                CFG_STALE_AGE:      stale_age_reg      <= cfg_data[31:0];
                default:            ;
            endcase
        end
    end

    frdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .own_id    (own_id_reg),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job_data  (job_data)
    );

    frdf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job_pop        (job_pop),
        .job_data       (job_data),
        .sweep_interval (sweep_interval_reg),
        .stale_age      (stale_age_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

endmodule

FILE: hdl/frdf_front.sv
// ----------------------------------------------------------------------------
// frdf_front
// Accepts input beats, flags self and time-to-live drops, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module frdf_front
    import frdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    input  logic [47:0] own_id,
    output logic        job_valid,
    input  logic        job_pop,
    output job_t        job_data
);

    localparam int unsigned QUEUE_DEPTH = 2;

    job_t       q_mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    job_t       job_in;

    // Classify the incoming beat
    always_comb
    begin
        job_in           = '0;
        job_in.pkt       = in_data;
        job_in.self_drop = (in_data.sender_id == own_id);
        job_in.ttl_drop  = in_data.hops_left[7] || (in_data.hops_left == 8'sd0);
    end

    assign in_stall  = (count_reg == 2'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_pop && job_valid;
    assign job_data  = q_mem_reg[rd_ptr_reg];

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/frdf_back.sv
// ----------------------------------------------------------------------------
// frdf_back
// Executes queued items against the sender table: walks the table one entry
// a cycle for lookup or stale sweep, updates it, and drives the result beat.
// ----------------------------------------------------------------------------
module frdf_back
    import frdf_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_pop,
    input  job_t        job_data,
    input  logic [31:0] sweep_interval,
    input  logic [31:0] stale_age,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TCHK,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t                   state_reg;
    job_t                     job_reg;
    logic [31:0]              local_time_reg;
    logic [31:0]              last_sweep_reg;
    logic                     sweep_reg;
    logic                     issue_on_reg;
    logic [IDX_W-1:0]         issue_idx_reg;
    logic                     chk_vld_reg;
    logic [IDX_W-1:0]         chk_idx_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [31:0]              hit_seq_reg;
    logic                     free_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [CNT_W-1:0]         removed_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    out_t                     res_reg;
    out_t                     out_reg;
    logic                     out_valid_reg;

    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_data_reg;

    logic                     chk_valid;
    logic                     id_match;
    logic                     stale;
    logic                     remove_now;
    logic [CNT_W-1:0]         removed_next;
    logic                     old_drop;
    logic                     fwd_now;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    entry_t                   mem_wdata;
    logic                     out_free;
    out_t                     self_res;

    // Compare the entry read back last cycle
    assign chk_valid    = valid_reg[chk_idx_reg];
    assign id_match     = (rd_data_reg.id == job_reg.pkt.sender_id);
    assign stale        = ((local_time_reg - rd_data_reg.stamp) > stale_age);
    assign remove_now   = chk_vld_reg && sweep_reg && chk_valid && stale;
    assign removed_next = (remove_now && (removed_reg != CNT_MAX))
                          ? removed_reg + CNT_W'(1) : removed_reg;

    // Decide on the packet once the walk is over
    assign old_drop  = hit_reg && (job_reg.pkt.seq_in <= hit_seq_reg);
    assign fwd_now   = (state_reg == S_DECIDE) && !old_drop && !job_reg.ttl_drop;
    assign mem_we    = fwd_now && (hit_reg || free_reg);
    assign mem_waddr = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        mem_wdata       = '0;
        mem_wdata.id    = job_reg.pkt.sender_id;
        mem_wdata.seq   = job_reg.pkt.seq_in;
        mem_wdata.stamp = job_reg.pkt.stamp;
    end

    // Result of a packet from this node
    always_comb
    begin
        self_res         = '0;
        self_res.verdict = VERDICT_DROP_SELF;
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sender table: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue_on_reg)
        begin
            rd_data_reg <= mem[issue_idx_reg];
        end
    end

    // Sequencer, table state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= '0;
            local_time_reg <= '0;
            last_sweep_reg <= '0;
            sweep_reg      <= 1'b0;
            issue_on_reg   <= 1'b0;
            issue_idx_reg  <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_seq_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            removed_reg    <= '0;
            valid_reg      <= '0;
            res_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Drop the output beat once taken, unless the next one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // Issue stage of the table walk
            chk_vld_reg <= issue_on_reg;
            chk_idx_reg <= issue_idx_reg;
            if (issue_on_reg)
            begin
                if (issue_idx_reg == LAST_IDX)
                begin
                    issue_on_reg <= 1'b0;
                end
                else
                begin
                    issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job_data;
                        sweep_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        if (job_data.pkt.action == ACTION_TIME)
                        begin
                            res_reg        <= '0;
                            local_time_reg <= job_data.pkt.stamp;
                            state_reg      <= S_TCHK;
                        end
                        else if (job_data.self_drop)
                        begin
                            res_reg   <= self_res;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            res_reg       <= '0;
                            issue_on_reg  <= 1'b1;
                            issue_idx_reg <= '0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end

                S_TCHK:
                begin
                    res_reg.verdict <= VERDICT_TIME;
                    if ((local_time_reg - last_sweep_reg) >= sweep_interval)
                    begin
                        last_sweep_reg <= local_time_reg;
                        sweep_reg      <= 1'b1;
                        removed_reg    <= '0;
                        issue_on_reg   <= 1'b1;
                        issue_idx_reg  <= '0;
                        state_reg      <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_SCAN:
                begin
                    if (chk_vld_reg)
                    begin
                        if (sweep_reg)
                        begin
                            removed_reg <= removed_next;
                            if (remove_now)
                            begin
                                valid_reg[chk_idx_reg] <= 1'b0;
                            end
                        end
                        else if (chk_valid)
                        begin
                            if (!hit_reg && id_match)
                            begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= chk_idx_reg;
                                hit_seq_reg <= rd_data_reg.seq;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= chk_idx_reg;
                        end

                        if (chk_idx_reg == LAST_IDX)
                        begin
                            if (sweep_reg)
                            begin
                                res_reg.swept         <= 1'b1;
                                res_reg.removed_count <= removed_next;
                                state_reg             <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_DECIDE;
                            end
                        end
                    end
                end

                S_DECIDE:
                begin
                    priority if (old_drop)
                    begin
                        res_reg.verdict <= VERDICT_DROP_OLD;
                    end
                    else if (job_reg.ttl_drop)
                    begin
                        res_reg.verdict <= VERDICT_DROP_TTL;
                    end
                    else
                    begin
                        res_reg.verdict      <= VERDICT_FWD;
                        res_reg.not_recorded <= !(hit_reg || free_reg);
                        res_reg.fwd_id       <= job_reg.pkt.sender_id;
                        res_reg.fwd_lat      <= job_reg.pkt.lat_bits;
                        res_reg.fwd_lon      <= job_reg.pkt.lon_bits;
                        res_reg.fwd_stamp    <= job_reg.pkt.stamp;
                        res_reg.fwd_hops     <= 7'(job_reg.pkt.hops_left[6:0] - 7'd1);
                        res_reg.fwd_seq      <= job_reg.pkt.seq_in;
                        if (hit_reg || free_reg)
                        begin
                            valid_reg[mem_waddr] <= 1'b1;
                        end
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/sv/flood_relay_duplicate_filter_top_tb.sv
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter_top_tb
// Self-checking bench for the mesh relay filter. Directed beats cover the
// reset register values, the drop rules and their precedence, the
// time-to-live limits and a full sender table with a sweep. Random traffic
// then runs under several register settings and idle patterns. Every accepted
// input beat is run through a local model of the filter, and each result beat
// is compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frdf_pkg::*;

    localparam int unsigned ENTRIES      = 16;
    localparam int unsigned POOL_SIZE    = 20;
    localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
    localparam int unsigned HOLD_OFF     = 300;
    localparam int unsigned IDLE_LIMIT   = 3000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_OWN_ID;
    logic [47:0] cfg_data  = '0;

    // Filter model state and register copies
    logic        tbl_used  [ENTRIES];
    logic [47:0] tbl_id    [ENTRIES];
    logic [31:0] tbl_seq   [ENTRIES];
    logic [31:0] tbl_stamp [ENTRIES];
    logic [31:0] now_time;
    logic [31:0] last_sweep;
    logic [47:0] node_id;
    logic [31:0] sweep_gap;
    logic [31:0] stale_limit;

    // Predicted result beats, oldest first
    out_t        pending_verdicts [$];
    out_t        head_result;

    // Stimulus state
    logic [47:0] sender_pool [POOL_SIZE];
    logic [31:0] seq_track   [POOL_SIZE];
    logic [31:0] wall_clock;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_req  = 0;
    int          hold_left     = 0;

    // Bookkeeping
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          results_seen   = 0;
    int          n_forward      = 0;
    int          n_dropped      = 0;
    int          n_unrecorded   = 0;
    int          n_sweeps       = 0;
    int          idle_cycles    = 0;

    flood_relay_duplicate_filter_top #(
        .TABLE_ENTRIES (ENTRIES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one beat and advance the model state
    function automatic out_t filter_verdict(input in_t it);
        out_t              r;
        int                hit;
        int                free_slot;
        int                gone;
        logic [31:0]       elapsed;
        logic [31:0]       age;
        logic signed [7:0] ttl;
        logic signed [7:0] ttl_dec;
        r = '0;
        if (it.action == ACTION_TIME)
        begin
            now_time  = it.stamp;
            r.verdict = VERDICT_TIME;
            elapsed   = now_time - last_sweep;
            if (elapsed >= sweep_gap)
            begin
                last_sweep = now_time;
                gone = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    age = now_time - tbl_stamp[i];
                    if (tbl_used[i] && age > stale_limit)
                    begin
                        tbl_used[i] = 1'b0;
                        gone++;
                    end
                end
                r.swept         = 1'b1;
                r.removed_count = (gone > 31) ? CNT_MAX : CNT_W'(gone);
            end
            return r;
        end

        // Find the sender's entry and the lowest free slot
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_used[i])
            begin
                if (hit < 0 && tbl_id[i] == it.sender_id)
                    hit = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end

        ttl = it.hops_left;
        if (it.sender_id == node_id)
            r.verdict = VERDICT_DROP_SELF;
        else if (hit >= 0 && it.seq_in <= tbl_seq[hit])
            r.verdict = VERDICT_DROP_OLD;
        else if (ttl <= 8'sd0)
            r.verdict = VERDICT_DROP_TTL;
        else
        begin
            if (hit < 0)
                hit = free_slot;
            if (hit >= 0)
            begin
                tbl_used[hit]  = 1'b1;
                tbl_id[hit]    = it.sender_id;
                tbl_seq[hit]   = it.seq_in;
                tbl_stamp[hit] = it.stamp;
            end
            else
                r.not_recorded = 1'b1;
            ttl_dec     = ttl - 8'sd1;
            r.verdict   = VERDICT_FWD;
            r.fwd_id    = it.sender_id;
            r.fwd_lat   = it.lat_bits;
            r.fwd_lon   = it.lon_bits;
            r.fwd_stamp = it.stamp;
            r.fwd_hops  = ttl_dec[6:0];
            r.fwd_seq   = it.seq_in;
        end
        return r;
    endfunction

    function automatic in_t packet_item(input logic [47:0] sid, input logic [31:0] seq,
                                        input logic signed [7:0] hops,
                                        input logic [31:0] stamp);
        in_t it;
        it           = '0;
        it.action    = ACTION_PACKET;
        it.sender_id = sid;
        it.lat_bits  = $urandom();
        it.lon_bits  = $urandom();
        it.stamp     = stamp;
        it.hops_left = hops;
        it.seq_in    = seq;
        return it;
    endfunction

    function automatic in_t time_item(input logic [31:0] stamp);
        in_t it;
        it           = packet_item({16'($urandom()), 32'($urandom())}, $urandom(),
                                   8'($urandom()), stamp);
        it.action    = ACTION_TIME;
        return it;
    endfunction

    // Mostly well-formed traffic from a fixed sender pool, some noise
    function automatic in_t random_item();
        in_t it;
        int  k;
        int  roll;
        it = packet_item({16'($urandom()), 32'($urandom())}, $urandom(),
                         8'($urandom()), $urandom());
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            it.action = 1'($urandom());
            if (it.action == ACTION_TIME)
                wall_clock = it.stamp;
            return it;
        end
        if (roll < 20)
        begin
            wall_clock += $urandom_range(0, 40);
            return time_item(wall_clock);
        end
        k = $urandom_range(0, POOL_SIZE - 1);
        it.sender_id = (roll < 25) ? node_id : sender_pool[k];
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            seq_track[k] += $urandom_range(1, 3);
            it.seq_in = seq_track[k];
        end
        else if (roll < 88)
            it.seq_in = seq_track[k] - $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 85)
            it.hops_left = 8'($urandom_range(1, 127));
        if ($urandom_range(0, 99) < 90)
            it.stamp = wall_clock - $urandom_range(0, 30);
        return it;
    endfunction

    // Offer one beat, hold it until taken, then log its prediction
    task automatic push_item(input in_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_verdicts = {pending_verdicts, filter_verdict(it)};
        items_sent++;
    endtask

    // Drop valid and wait until every predicted beat has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OWN_ID:         node_id     = val;
            CFG_SWEEP_INTERVAL: sweep_gap   = val[31:0];
            CFG_STALE_AGE:      stale_limit = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_filter_config(input logic [47:0] own, input logic [31:0] gap,
                                     input logic [31:0] age_max);
        wait_idle();
        write_reg(CFG_OWN_ID, own);
        write_reg(CFG_SWEEP_INTERVAL, {16'd0, gap});
        write_reg(CFG_STALE_AGE, {16'd0, age_max});
    endtask

    // Reset values: own id 0, sweep after 5000, stale after 10
    task automatic test_reset_defaults();
        push_item(packet_item(48'd0, 32'd7, 8'sd9, 32'd0));
        push_item(packet_item(48'h0000_1234_5678, 32'd1, 8'sd5, 32'd0));
        push_item(time_item(32'd4999));
        push_item(time_item(32'd5000));
    endtask

    // Drop causes, their precedence and the time-to-live limits
    task automatic test_drop_rules();
        set_filter_config('1, 32'd0, 32'd0);
        push_item(packet_item('1, 32'd0, 8'sd0, 32'd1000));
        push_item(packet_item(48'hA5A5_0000_0001, 32'd5, 8'sd127, 32'd1000));
        push_item(packet_item(48'hA5A5_0000_0001, 32'd5, 8'sd0, 32'd1000));
        push_item(packet_item(48'hA5A5_0000_0001, 32'd4, 8'sd3, 32'd1000));
        push_item(packet_item(48'hA5A5_0000_0001, 32'd6, 8'sd0, 32'd1000));
        push_item(packet_item(48'hA5A5_0000_0001, 32'd6, 8'sh80, 32'd1000));
        push_item(packet_item(48'hA5A5_0000_0001, '1, 8'sd1, 32'd1000));
        push_item(packet_item(48'd0, 32'd0, 8'sd1, 32'd1000));
    endtask

    // Self beats old; fill the table, overflow it, then sweep it clean
    task automatic test_table_full();
        set_filter_config(48'hA5A5_0000_0001, 32'd0, 32'd0);
        push_item(packet_item(48'hA5A5_0000_0001, 32'd0, 8'sd0, 32'd1000));
        for (int n = 0; n < ENTRIES - 2; n++)
            push_item(packet_item(48'h5000_0000_0000 + n, 32'd1, 8'sd10, 32'd1000));
        push_item(packet_item(48'h5FFF_0000_0000, 32'd1, 8'sd10, 32'd1000));
        push_item(time_item(32'd1001));
        push_item(packet_item(48'h5FFF_0000_0000, 32'd1, 8'sd10, 32'd1001));
        wall_clock = 32'd1001;
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int n = 0; n < n_items; n++)
            push_item(random_item());
    endtask

    // Hold the output off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        hold_off_req = HOLD_OFF;
        for (int n = 0; n < 16; n++)
            push_item(random_item());
    endtask

    task automatic check_field(input string fname, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                         fname, results_seen, want_v, got_v);
        end
    endtask

    // Receiver: random stall, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_req > 0)
        begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing outstanding: 0x%0h",
                             results_seen, out_data);
            end
            else
            begin
                head_result = pending_verdicts.pop_front();
                check_field("verdict", 64'(head_result.verdict), 64'(out_data.verdict));
                check_field("not_recorded", 64'(head_result.not_recorded),
                            64'(out_data.not_recorded));
                check_field("fwd_id", 64'(head_result.fwd_id), 64'(out_data.fwd_id));
                check_field("fwd_lat", 64'(head_result.fwd_lat), 64'(out_data.fwd_lat));
                check_field("fwd_lon", 64'(head_result.fwd_lon), 64'(out_data.fwd_lon));
                check_field("fwd_stamp", 64'(head_result.fwd_stamp),
                            64'(out_data.fwd_stamp));
                check_field("fwd_hops", 64'(head_result.fwd_hops), 64'(out_data.fwd_hops));
                check_field("fwd_seq", 64'(head_result.fwd_seq), 64'(out_data.fwd_seq));
                check_field("swept", 64'(head_result.swept), 64'(out_data.swept));
                check_field("removed_count", 64'(head_result.removed_count),
                            64'(out_data.removed_count));
                if (head_result.verdict == VERDICT_FWD)
                    n_forward++;
                else if (head_result.verdict != VERDICT_TIME)
                    n_dropped++;
                n_unrecorded += head_result.not_recorded;
                n_sweeps     += head_result.swept;
            end
        end
    end

    // Watchdog: end the run when no beat has moved for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        // Model reset state
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_used[i]  = 1'b0;
            tbl_id[i]    = '0;
            tbl_seq[i]   = '0;
            tbl_stamp[i] = '0;
        end
        now_time    = '0;
        last_sweep  = '0;
        node_id     = OWN_ID_RST;
        sweep_gap   = SWEEP_INTERVAL_RST;
        stale_limit = STALE_AGE_RST;
        wall_clock  = '0;

        // Sender pool, with the all-ones and all-zero ids among them
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            sender_pool[k] = {16'($urandom()), 32'($urandom())};
            seq_track[k]   = $urandom();
        end
        sender_pool[0] = '1;
        sender_pool[1] = '0;
        seq_track[2]   = 32'hFFFF_FFF0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 83;
        test_reset_defaults();
        test_drop_rules();
        test_table_full();

        set_filter_config(sender_pool[3], 32'd50, 32'd30);
        test_random_traffic(175);

        send_idle_pct = 83;
        recv_idle_pct = 24;
        set_filter_config({16'($urandom()), 32'($urandom())}, 32'd0, '1);
        test_random_traffic(175);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_filter_config(48'd0, '1, 32'd5);
        test_random_traffic(175);

        set_filter_config(sender_pool[2], 32'd20, 32'd15);
        test_random_traffic(175);
        test_output_backpressure();

        // Drain, then report
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            mismatch_count += pending_verdicts.size();
            $display("%0d predicted results never arrived", pending_verdicts.size());
        end
        $display("run covered %0d beats in, %0d results: %0d forwarded, %0d dropped",
                 items_sent, results_seen, n_forward, n_dropped);
        $display("  %0d forwarded unrecorded, %0d sweeps, %0d mismatches",
                 n_unrecorded, n_sweeps, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
